### hw/rtl/fpvn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpvn_pkg
// Shared widths and constants for the Q16.16 vector normalizer.
// ----------------------------------------------------------------------------
package fpvn_pkg;
  localparam int CompW  = 32;
  localparam int MagW   = 24;
  localparam int FracW  = 16;
  localparam int NumW   = CompW + FracW;   // component times 65536
  localparam int Lanes  = 3;
  localparam int SqSt   = 2;               // square and sum stages
  localparam int RootSt = MagW;            // one root bit per stage
  localparam int DivSt  = NumW;            // one quotient bit per stage

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic        [MagW-1:0]  mag_t;

  typedef struct packed {
    logic [CompW-1:0] unit;
  } lane_out_t;
endpackage

### hw/rtl/fpvn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpvn_in_if / fpvn_out_if
// Valid/ready channels carrying a vector and a normalized result.
// ----------------------------------------------------------------------------
interface fpvn_in_if import fpvn_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t vec_x;
  comp_t vec_y;
  comp_t vec_z;
  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface fpvn_out_if import fpvn_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t unit_x;
  comp_t unit_y;
  comp_t unit_z;
  mag_t  length;
  logic  zero_length;
  modport source (output valid, unit_x, unit_y, unit_z, length, zero_length, input ready);
  modport sink (input valid, unit_x, unit_y, unit_z, length, zero_length, output ready);
endinterface

### hw/rtl/fpvn_mag.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpvn_mag
// Pipelined squares, wrapped sum and 24-stage restoring square root.
// ----------------------------------------------------------------------------
module fpvn_mag import fpvn_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  comp_t vx,
  input  comp_t vy,
  input  comp_t vz,
  output mag_t  mag
);
  logic [CompW-1:0] sq [Lanes];
  logic [CompW-1:0] sum;
  logic [CompW-1:0] lo   [RootSt+1];
  logic [MagW+1:0]  hi   [RootSt+1];
  logic [MagW-1:0]  root [RootSt+1];

  // one multiplier per lane, bits 47:16 of the signed square
  always_ff @(posedge clk) begin
    if (en) begin
      sq[0] <= CompW'((64'(signed'(vx)) * 64'(signed'(vx))) >> FracW);
      sq[1] <= CompW'((64'(signed'(vy)) * 64'(signed'(vy))) >> FracW);
      sq[2] <= CompW'((64'(signed'(vz)) * 64'(signed'(vz))) >> FracW);
      sum   <= sq[0] + sq[1] + sq[2];
    end
  end

  assign lo[0]   = sum;
  assign hi[0]   = '0;
  assign root[0] = '0;

  for (genvar k = 0; k < RootSt; k++) begin : g_root
    logic [MagW+1:0] h2;
    logic [MagW+1:0] trial;
    logic [MagW-1:0] r2;
    always_comb begin
      h2    = {hi[k][MagW-1:0], lo[k][CompW-1 -: 2]};
      r2    = {root[k][MagW-2:0], 1'b0};
      trial = {1'b0, r2, 1'b1};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        lo[k+1]   <= {lo[k][CompW-3:0], 2'b00};
        hi[k+1]   <= (h2 >= trial) ? h2 - trial : h2;
        root[k+1] <= (h2 >= trial) ? (r2 | MagW'(1)) : r2;
      end
    end
  end

  assign mag = root[RootSt];
endmodule

### hw/rtl/fpvn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpvn_div
// One lane: pipelined restoring division of |comp|*65536 by the magnitude,
// one quotient bit per stage, sign restored at the end.
// ----------------------------------------------------------------------------
module fpvn_div import fpvn_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  comp_t     comp,
  input  mag_t      mag,
  output lane_out_t res
);
  logic [NumW-1:0] num [DivSt+1];
  logic [MagW:0]   rem [DivSt+1];
  logic [MagW-1:0] dv  [DivSt+1];
  logic            neg [DivSt+1];

  always_comb begin
    num[0] = {(comp[CompW-1] ? CompW'(-comp) : CompW'(comp)), {FracW{1'b0}}};
    rem[0] = '0;
    dv[0]  = mag;
    neg[0] = comp[CompW-1];
  end

  for (genvar k = 0; k < DivSt; k++) begin : g_div
    logic [MagW+1:0] r2;
    always_comb r2 = {rem[k], num[k][NumW-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1]  <= dv[k];
        neg[k+1] <= neg[k];
        if (r2 >= {2'b00, dv[k]}) begin
          rem[k+1] <= (MagW+1)'(r2 - {2'b00, dv[k]});
          num[k+1] <= {num[k][NumW-2:0], 1'b1};
        end else begin
          rem[k+1] <= r2[MagW:0];
          num[k+1] <= {num[k][NumW-2:0], 1'b0};
        end
      end
    end
  end

  // zero divisor yields zero
  always_comb begin
    if (dv[DivSt] == '0) res.unit = '0;
    else if (neg[DivSt]) res.unit = -num[DivSt][CompW-1:0];
    else res.unit = num[DivSt][CompW-1:0];
  end
endmodule

### hw/rtl/fixed_point_vector_normalize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_vector_normalize
// Q16.16 3D vector normalizer, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one vector per cycle while the output is not stalled, and returns
// its unit vector and length: two stages square and sum the components, 24
// stages each settle one bit of the root, then three parallel division lanes
// each settle one quotient bit per stage over 48 stages, and an output
// register holds the result. The whole pipeline stalls while a result waits
// at the output. A zero length gives zero components with zero_length set.
module fixed_point_vector_normalize import fpvn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fpvn_in_if.sink    in_ch,
  fpvn_out_if.source out_ch
);
  localparam int Lat = SqSt + RootSt + DivSt;

  logic      en;
  logic      vld [Lat];
  comp_t     cx [SqSt+RootSt];
  comp_t     cy [SqSt+RootSt];
  comp_t     cz [SqSt+RootSt];
  mag_t      mpipe [DivSt];
  mag_t      mag;
  lane_out_t lx, ly, lz;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  fpvn_mag u_mag (.clk, .en, .vx(in_ch.vec_x), .vy(in_ch.vec_y), .vz(in_ch.vec_z), .mag);

  // delay the components to meet the root
  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= in_ch.vec_x;
      cy[0] <= in_ch.vec_y;
      cz[0] <= in_ch.vec_z;
      for (int i = 1; i < SqSt + RootSt; i++) begin
        cx[i] <= cx[i-1];
        cy[i] <= cy[i-1];
        cz[i] <= cz[i-1];
      end
      mpipe[0] <= mag;
      for (int i = 1; i < DivSt; i++) mpipe[i] <= mpipe[i-1];
    end
  end

  fpvn_div u_dx (.clk, .en, .comp(cx[SqSt+RootSt-1]), .mag, .res(lx));
  fpvn_div u_dy (.clk, .en, .comp(cy[SqSt+RootSt-1]), .mag, .res(ly));
  fpvn_div u_dz (.clk, .en, .comp(cz[SqSt+RootSt-1]), .mag, .res(lz));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Lat; i++) vld[i] <= 1'b0;
      out_ch.valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_ch.valid;
      for (int i = 1; i < Lat; i++) vld[i] <= vld[i-1];
      out_ch.valid <= vld[Lat-1];
    end
  end

  // merge the lanes into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.unit_x      <= lx.unit;
      out_ch.unit_y      <= ly.unit;
      out_ch.unit_z      <= lz.unit;
      out_ch.length      <= mpipe[DivSt-1];
      out_ch.zero_length <= (mpipe[DivSt-1] == '0);
    end
  end

  a_zero_units: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.zero_length |-> out_ch.unit_x == '0 && out_ch.unit_y == '0
      && out_ch.unit_z == '0)
    else $error("zero length with nonzero components");
  a_flag_len: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.zero_length == (out_ch.length == '0))
    else $error("zero flag disagrees with length");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.length))
    else $error("result lost during stall");
endmodule
